FILE: src/bclp_pkg.sv
package bclp_pkg;

  localparam int unsigned TimeW     = 32;
  localparam int unsigned DebounceW = 8;
  localparam int unsigned ThreshW   = 16;
  localparam int unsigned ClicksW   = 8;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 16;

  typedef enum logic [CfgIdxW-1:0] {
    CfgDebounceTime  = 2'd0,
    CfgClickTime     = 2'd1,
    CfgLongPressTime = 2'd2,
    CfgPressedLevel  = 2'd3
  } cfg_idx_e;

  localparam logic [DebounceW-1:0] DebounceRst  = 8'd50;
  localparam logic [ThreshW-1:0]   ClickRst     = 16'd150;
  localparam logic [ThreshW-1:0]   LongPressRst = 16'd1000;

  typedef enum logic [1:0] {
    StIdle = 2'd0,
    StDown = 2'd1,
    StUp   = 2'd2,
    StLong = 2'd3
  } state_e;

  typedef struct packed {
    logic [DebounceW-1:0] debounce_time;
    logic [ThreshW-1:0]   click_time;
    logic [ThreshW-1:0]   long_press_time;
    logic                 pressed_level;
  } config_t;

  typedef struct packed {
    logic               button_pressed;
    logic [ClicksW-1:0] click_count;
    logic               long_active;
    logic [TimeW-1:0]   start_time;
    logic               ev_transition;
    logic               ev_each_click;
    logic               ev_done_clicking;
    logic               ev_single_click;
    logic               ev_double_click;
    logic               ev_long_start;
    logic               ev_long_held;
    logic               ev_long_end;
  } result_t;

endpackage

FILE: src/bclp_if.sv
interface bclp_in_if;
  logic                         valid;
  logic                         ready;
  logic [bclp_pkg::TimeW-1:0]   now_ms;
  logic                         pin_level;

  modport source (output valid, output now_ms, output pin_level, input ready);
  modport sink   (input valid, input now_ms, input pin_level, output ready);
endinterface

interface bclp_out_if;
  logic                         valid;
  logic                         ready;
  logic                         button_pressed;
  logic [bclp_pkg::ClicksW-1:0] click_count;
  logic                         long_active;
  logic [bclp_pkg::TimeW-1:0]   start_time;
  logic                         ev_transition;
  logic                         ev_each_click;
  logic                         ev_done_clicking;
  logic                         ev_single_click;
  logic                         ev_double_click;
  logic                         ev_long_start;
  logic                         ev_long_held;
  logic                         ev_long_end;

  modport source (
    output valid, input ready,
    output button_pressed, output click_count, output long_active, output start_time,
    output ev_transition, output ev_each_click, output ev_done_clicking,
    output ev_single_click, output ev_double_click, output ev_long_start,
    output ev_long_held, output ev_long_end
  );
  modport sink (
    input valid, output ready,
    input button_pressed, input click_count, input long_active, input start_time,
    input ev_transition, input ev_each_click, input ev_done_clicking,
    input ev_single_click, input ev_double_click, input ev_long_start,
    input ev_long_held, input ev_long_end
  );
endinterface

FILE: src/bclp_core.sv
module bclp_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       step_i,
  input  logic [bclp_pkg::TimeW-1:0] now_i,
  input  logic                       pin_i,
  input  bclp_pkg::config_t          cfg_i,
  output bclp_pkg::result_t          result_o
);

  bclp_pkg::state_e                 state_q, state_d;
  logic [bclp_pkg::ClicksW-1:0]     clicks_q, clicks_d;
  logic [bclp_pkg::TimeW-1:0]       first_q, first_d;
  logic [bclp_pkg::TimeW-1:0]       last_q, last_d;
  logic                             sample_q, sample_d;

  logic [bclp_pkg::TimeW-1:0] since;
  logic                       sampling;
  logic                       pressed;
  logic                       long_due;
  logic                       click_due;

  assign since     = now_i - last_q;
  assign sampling  = since >= {{(bclp_pkg::TimeW-bclp_pkg::DebounceW){1'b0}},
                               cfg_i.debounce_time};
  assign pressed   = pin_i == cfg_i.pressed_level;
  assign long_due  = since >= {{(bclp_pkg::TimeW-bclp_pkg::ThreshW){1'b0}},
                               cfg_i.long_press_time};
  assign click_due = since >= {{(bclp_pkg::TimeW-bclp_pkg::ThreshW){1'b0}},
                               cfg_i.click_time};

  // next state
  always_comb begin
    state_d = state_q;
    if (sampling) begin
      case (state_q)
        bclp_pkg::StIdle: if (pressed) state_d = bclp_pkg::StDown;
        bclp_pkg::StDown: begin
          if (!pressed) state_d = bclp_pkg::StUp;
          else if (long_due) state_d = bclp_pkg::StLong;
        end
        bclp_pkg::StUp: begin
          if (pressed) state_d = bclp_pkg::StDown;
          else if (click_due) state_d = bclp_pkg::StIdle;
        end
        bclp_pkg::StLong: if (!pressed) state_d = bclp_pkg::StIdle;
        default: state_d = bclp_pkg::StIdle;
      endcase
    end
  end

  // datapath and event flags
  always_comb begin
    clicks_d = clicks_q;
    first_d  = first_q;
    last_d   = last_q;
    sample_d = sample_q;
    result_o = '0;
    result_o.ev_long_held = state_q == bclp_pkg::StLong;
    if (sampling) begin
      sample_d = pressed;
      case (state_q)
        bclp_pkg::StIdle: begin
          if (pressed) begin
            first_d = now_i;
            last_d  = now_i;
            result_o.ev_transition = 1'b1;
          end
        end
        bclp_pkg::StDown: begin
          if (!pressed) begin
            clicks_d = clicks_q + bclp_pkg::ClicksW'(1);
            last_d   = now_i;
            result_o.ev_transition = 1'b1;
            result_o.ev_each_click = 1'b1;
          end else if (long_due) begin
            result_o.ev_long_start = 1'b1;
          end
        end
        bclp_pkg::StUp: begin
          if (pressed) begin
            last_d = now_i;
            result_o.ev_transition = 1'b1;
          end else if (click_due) begin
            result_o.ev_done_clicking = 1'b1;
            result_o.ev_single_click  = clicks_q == bclp_pkg::ClicksW'(1);
            result_o.ev_double_click  = clicks_q == bclp_pkg::ClicksW'(2);
            clicks_d = '0;
            first_d  = '0;
          end
        end
        bclp_pkg::StLong: begin
          if (!pressed) begin
            last_d   = now_i;
            clicks_d = '0;
            first_d  = '0;
            result_o.ev_transition = 1'b1;
            result_o.ev_long_end   = 1'b1;
          end
        end
        default: ;
      endcase
    end
    result_o.button_pressed = sample_d;
    result_o.click_count    = clicks_d;
    result_o.long_active    = state_d == bclp_pkg::StLong;
    result_o.start_time     = first_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= bclp_pkg::StIdle;
      clicks_q <= '0;
      first_q  <= '0;
      last_q   <= '0;
      sample_q <= 1'b0;
    end else if (step_i) begin
      state_q  <= state_d;
      clicks_q <= clicks_d;
      first_q  <= first_d;
      last_q   <= last_d;
      sample_q <= sample_d;
    end
  end

endmodule

FILE: src/button_click_long_press_detector.sv
// Button click and long-press detector. Each poll (a millisecond timestamp and the raw
// pin level) yields one result with the debounced pressed flag, the click count, the
// long-pressed flag, the sequence start time and one pulse per event. Polls pass
// through an input register and a result register; a new poll is taken every cycle
// while the output side is ready. The state update for one poll is a single pass of
// subtract-and-compare logic in bclp_core. The user must write configuration registers
// through the plain write port while no poll is in flight; this is not enforced.
module button_click_long_press_detector (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bclp_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [bclp_pkg::CfgDataW-1:0] cfg_data_i,
  bclp_in_if.sink                       in_if,
  bclp_out_if.source                    out_if
);

  bclp_pkg::config_t          cfg_q;
  logic                       s1_valid_q;
  logic [bclp_pkg::TimeW-1:0] s1_now_q;
  logic                       s1_pin_q;
  logic                       out_valid_q;
  bclp_pkg::result_t          res_q;
  bclp_pkg::result_t          res_d;
  logic                       advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_time   <= bclp_pkg::DebounceRst;
      cfg_q.click_time      <= bclp_pkg::ClickRst;
      cfg_q.long_press_time <= bclp_pkg::LongPressRst;
      cfg_q.pressed_level   <= 1'b0;
    end else if (cfg_we_i) begin
      case (bclp_pkg::cfg_idx_e'(cfg_idx_i))
        bclp_pkg::CfgDebounceTime:  cfg_q.debounce_time <= cfg_data_i[bclp_pkg::DebounceW-1:0];
        bclp_pkg::CfgClickTime:     cfg_q.click_time <= cfg_data_i[bclp_pkg::ThreshW-1:0];
        bclp_pkg::CfgLongPressTime: cfg_q.long_press_time <= cfg_data_i[bclp_pkg::ThreshW-1:0];
        bclp_pkg::CfgPressedLevel:  cfg_q.pressed_level <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // the poll in the input register moves on when the result register is free
  assign advance     = s1_valid_q && (!out_valid_q || out_if.ready);
  assign in_if.ready = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_if.ready) begin
      s1_valid_q <= in_if.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) begin
      s1_now_q <= in_if.now_ms;
      s1_pin_q <= in_if.pin_level;
    end
  end

  bclp_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .now_i    (s1_now_q),
    .pin_i    (s1_pin_q),
    .cfg_i    (cfg_q),
    .result_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_if.valid            = out_valid_q;
  assign out_if.button_pressed   = res_q.button_pressed;
  assign out_if.click_count      = res_q.click_count;
  assign out_if.long_active      = res_q.long_active;
  assign out_if.start_time       = res_q.start_time;
  assign out_if.ev_transition    = res_q.ev_transition;
  assign out_if.ev_each_click    = res_q.ev_each_click;
  assign out_if.ev_done_clicking = res_q.ev_done_clicking;
  assign out_if.ev_single_click  = res_q.ev_single_click;
  assign out_if.ev_double_click  = res_q.ev_double_click;
  assign out_if.ev_long_start    = res_q.ev_long_start;
  assign out_if.ev_long_held     = res_q.ev_long_held;
  assign out_if.ev_long_end      = res_q.ev_long_end;

endmodule
